FILE: src/rhc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RGB to HSV converter.
// Depends on nothing; used by rgb_to_hsv_converter.
package rhc_pkg;

   localparam int CHAN_W     = 8;
   localparam int HUE_W      = 9;
   localparam int DIV_STEPS  = 8;
   localparam int HUE_NUM_W  = 14;
   localparam int SAT_NUM_W  = 16;
   localparam int NUM_STAGES = DIV_STEPS + 3;

   localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 9'd120;
   localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 9'd240;
   localparam logic [HUE_W-1:0] HUE_WRAP       = 9'd360;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } rsp_type;

   // Per-pixel facts that ride alongside the dividers.
   typedef struct packed {
      sector_type        sector;
      logic              neg;
      logic              grey;
      logic              black;
      logic [CHAN_W-1:0] brightness;
   } side_type;

endpackage

FILE: src/rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
// Top level of the RGB to HSV converter: front end, scaling, output stage.
// Depends on rhc_pkg and rhc_divider.
//
// Usage
// -----
// Pixels enter on the req_ channel (req_valid, req_ready, req_data) and
// HSV results leave on the rsp_ channel (rsp_valid, rsp_ready, rsp_data).
// A transaction completes on a rising edge where valid and ready are both
// high. Every input transaction yields exactly one result, in order.
// The block is a pipeline of eleven register stages: channel max/min and
// hue sector, scaling of the two numerators, eight restoring divider steps
// (one quotient bit each, hue and saturation side by side) and the final
// hue offset stage. Throughput is one pixel per clock; the divider depth
// sets the latency, not the rate. Each stage holds a valid bit and
// advances whenever the stage after it is empty or advancing, so bubbles
// are squeezed out and new pixels are taken while a finished result
// waits at the output. When the receiver stalls, results back up stage by
// stage and req_ready falls only once the whole pipeline is full; nothing
// is lost or repeated. Synchronous reset clears all valid bits; data
// registers are not reset.
module rgb_to_hsv_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rhc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rhc_pkg::rsp_type rsp_data
);

   localparam int NS    = rhc_pkg::NUM_STAGES;
   localparam int STEPS = rhc_pkg::DIV_STEPS;
   localparam int CW    = rhc_pkg::CHAN_W;
   localparam int HW    = rhc_pkg::HUE_W;

   // ---------------------------------------------------------------
   // Flow control: one valid bit per stage, ready ripples backwards.
   // ---------------------------------------------------------------
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   ready_chain;

   always_comb begin
      ready_chain[NS] = rsp_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         ready_chain[i] = ~valid_ff[i] | ready_chain[i+1];
      end
      valid_in = ({valid_ff[NS-2:0], req_valid} & ready_chain[NS-1:0])
               | (valid_ff & ~ready_chain[NS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = ready_chain[0];
   assign rsp_valid = valid_ff[NS-1];

   // ---------------------------------------------------------------
   // Stage 0: largest channel, smallest channel and the signed channel
   // difference that drives the hue. Red wins ties, then green.
   // ---------------------------------------------------------------
   rhc_pkg::sector_type front_sector_in, front_sector_ff;
   logic          front_neg_in, front_neg_ff;
   logic [CW-1:0] front_mag_in, front_mag_ff;
   logic [CW-1:0] front_max_in, front_max_ff;
   logic [CW-1:0] front_delta_in, front_delta_ff;

   always_comb begin
      logic [CW-1:0] red, green, blue, op_a, op_b, min_val;
      red   = req_data.red;
      green = req_data.green;
      blue  = req_data.blue;
      if (red >= green && red >= blue) begin
         front_sector_in = rhc_pkg::SECTOR_RED;
         front_max_in    = red;
         op_a            = green;
         op_b            = blue;
      end else if (green >= blue) begin
         front_sector_in = rhc_pkg::SECTOR_GREEN;
         front_max_in    = green;
         op_a            = blue;
         op_b            = red;
      end else begin
         front_sector_in = rhc_pkg::SECTOR_BLUE;
         front_max_in    = blue;
         op_a            = red;
         op_b            = green;
      end
      min_val = (red < green) ? red : green;
      if (blue < min_val) begin
         min_val = blue;
      end
      front_delta_in = front_max_in - min_val;
      front_neg_in   = op_a < op_b;
      front_mag_in   = front_neg_in ? (op_b - op_a) : (op_a - op_b);
   end

   always_ff @(posedge clock) begin
      if (ready_chain[0]) begin
         front_sector_ff <= front_sector_in;
         front_neg_ff    <= front_neg_in;
         front_mag_ff    <= front_mag_in;
         front_max_ff    <= front_max_in;
         front_delta_ff  <= front_delta_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: numerators 60*|diff| and 255*delta by shift and subtract.
   // ---------------------------------------------------------------
   logic [rhc_pkg::HUE_NUM_W-1:0] scale_hue_num_in, scale_hue_num_ff;
   logic [rhc_pkg::SAT_NUM_W-1:0] scale_sat_num_in, scale_sat_num_ff;
   logic [CW-1:0]                 scale_delta_ff;
   logic [CW-1:0]                 scale_max_ff;
   rhc_pkg::side_type             scale_side_in, scale_side_ff;

   always_comb begin
      scale_hue_num_in = (rhc_pkg::HUE_NUM_W'(front_mag_ff) << 6)
                       - (rhc_pkg::HUE_NUM_W'(front_mag_ff) << 2);
      scale_sat_num_in = (rhc_pkg::SAT_NUM_W'(front_delta_ff) << 8)
                       - rhc_pkg::SAT_NUM_W'(front_delta_ff);
      scale_side_in.sector     = front_sector_ff;
      scale_side_in.neg        = front_neg_ff;
      scale_side_in.grey       = (front_delta_ff == '0);
      scale_side_in.black      = (front_max_ff == '0);
      scale_side_in.brightness = front_max_ff;
   end

   always_ff @(posedge clock) begin
      if (ready_chain[1]) begin
         scale_hue_num_ff <= scale_hue_num_in;
         scale_sat_num_ff <= scale_sat_num_in;
         scale_delta_ff   <= front_delta_ff;
         scale_max_ff     <= front_max_ff;
         scale_side_ff    <= scale_side_in;
      end
   end

   // ---------------------------------------------------------------
   // Stages 2 to 9: the two dividers, with the pixel facts alongside.
   // ---------------------------------------------------------------
   logic [STEPS-1:0]              div_en;
   logic [STEPS-1:0]              hue_quo;
   logic [rhc_pkg::HUE_NUM_W-1:0] hue_rem;
   logic [STEPS-1:0]              sat_quo;
   logic [rhc_pkg::SAT_NUM_W-1:0] sat_rem;
   rhc_pkg::side_type             side_ff [STEPS];

   assign div_en = ready_chain[STEPS+1:2];

   rhc_divider #(
      .STEPS (STEPS),
      .NUM_W (rhc_pkg::HUE_NUM_W),
      .DEN_W (CW)
   ) u_hue_div (
      .clock   (clock),
      .en      (div_en),
      .num_in  (scale_hue_num_ff),
      .den_in  (scale_delta_ff),
      .quo_out (hue_quo),
      .rem_out (hue_rem)
   );

   // The saturation remainder is not needed; the quotient is floored.
   rhc_divider #(
      .STEPS (STEPS),
      .NUM_W (rhc_pkg::SAT_NUM_W),
      .DEN_W (CW)
   ) u_sat_div (
      .clock   (clock),
      .en      (div_en),
      .num_in  (scale_sat_num_ff),
      .den_in  (scale_max_ff),
      .quo_out (sat_quo),
      .rem_out (sat_rem)
   );

   always_ff @(posedge clock) begin
      if (div_en[0]) begin
         side_ff[0] <= scale_side_ff;
      end
      for (int j = 1; j < STEPS; j++) begin
         if (div_en[j]) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 10: sector offset and truncation toward zero. With q the
   // floored quotient, a negative difference gives -q for the red
   // sector (wrapped by 360 when non-zero) and base - q - 1 for the
   // others whenever the division was inexact.
   // ---------------------------------------------------------------
   rhc_pkg::rsp_type out_in, out_ff;

   always_comb begin
      rhc_pkg::side_type side;
      logic [HW-1:0]     quo;
      logic [HW-1:0]     inexact;
      side    = side_ff[STEPS-1];
      quo     = HW'(hue_quo);
      inexact = HW'(hue_rem != '0);
      case (side.sector)
         rhc_pkg::SECTOR_RED: begin
            if (!side.neg) begin
               out_in.hue = quo;
            end else if (quo == '0) begin
               out_in.hue = '0;
            end else begin
               out_in.hue = rhc_pkg::HUE_WRAP - quo;
            end
         end
         rhc_pkg::SECTOR_GREEN: begin
            out_in.hue = side.neg ? (rhc_pkg::HUE_GREEN_BASE - quo - inexact)
                                  : (rhc_pkg::HUE_GREEN_BASE + quo);
         end
         rhc_pkg::SECTOR_BLUE: begin
            out_in.hue = side.neg ? (rhc_pkg::HUE_BLUE_BASE - quo - inexact)
                                  : (rhc_pkg::HUE_BLUE_BASE + quo);
         end
         default: begin
            out_in.hue = '0;
         end
      endcase
      if (side.grey) begin
         out_in.hue = '0;
      end
      out_in.saturation = side.black ? '0 : (sat_quo ^ CW'(sat_rem & '0));
      out_in.brightness = side.brightness;
   end

   always_ff @(posedge clock) begin
      if (ready_chain[NS-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule

FILE: src/rhc_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; instantiated twice by rgb_to_hsv_converter.
module rhc_divider #(
   parameter int STEPS = 8,
   parameter int NUM_W = 16,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic [STEPS-1:0] en,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [STEPS-1:0] quo_out,
   output logic [NUM_W-1:0] rem_out
);

   localparam int CMP_W = DEN_W + STEPS;

   logic [NUM_W-1:0] rem_ff [STEPS];
   logic [STEPS-1:0] quo_ff [STEPS];
   logic [DEN_W-1:0] den_ff [STEPS-1];

   // The numerator must stay below den << STEPS for the quotient to fit.
   genvar j;
   generate
      for (j = 0; j < STEPS; j++) begin : g_step
         localparam int K = STEPS - 1 - j;
         logic [NUM_W-1:0] rem_prev;
         logic [STEPS-1:0] quo_prev;
         logic [DEN_W-1:0] den_prev;
         logic [CMP_W:0]   diff;
         logic             q_bit;
         logic [NUM_W-1:0] rem_in;
         logic [STEPS-1:0] quo_in;

         if (j == 0) begin : g_first
            assign rem_prev = num_in;
            assign quo_prev = '0;
            assign den_prev = den_in;
         end else begin : g_next
            assign rem_prev = rem_ff[j-1];
            assign quo_prev = quo_ff[j-1];
            assign den_prev = den_ff[j-1];
         end

         always_comb begin
            diff   = (CMP_W+1)'(rem_prev) - (((CMP_W+1)'(den_prev)) << K);
            q_bit  = ~diff[CMP_W];
            rem_in = q_bit ? diff[NUM_W-1:0] : rem_prev;
            quo_in = {quo_prev[STEPS-2:0], q_bit};
         end

         always_ff @(posedge clock) begin
            if (en[j]) begin
               rem_ff[j] <= rem_in;
               quo_ff[j] <= quo_in;
            end
         end

         if (j < STEPS - 1) begin : g_den
            always_ff @(posedge clock) begin
               if (en[j]) begin
                  den_ff[j] <= den_prev;
               end
            end
         end
      end
   endgenerate

   assign quo_out = quo_ff[STEPS-1];
   assign rem_out = rem_ff[STEPS-1];

endmodule
